// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL. Every macro expects signals named clk and
// rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/stx_pkg.sv =====
// ----------------------------------------------------------------------------
// stx_pkg
// Constants and the result item type for the sensor telegram receiver.
// ----------------------------------------------------------------------------
package stx_pkg;

    localparam logic [7:0] ACK_CODE  = 8'h06;
    localparam int         HDR_BYTES = 5;
    localparam int         CRC_BYTES = 2;

    localparam int HDR_CNT_W = $clog2(HDR_BYTES);
    localparam int LEN_W     = 16;
    localparam int IDX_W     = LEN_W + 1;
    localparam int ID_W      = 32;

    // Header positions of the length bytes and the command byte
    localparam logic [HDR_CNT_W-1:0] HDR_POS_LEN_LO = HDR_CNT_W'(2);
    localparam logic [HDR_CNT_W-1:0] HDR_POS_LEN_HI = HDR_CNT_W'(3);
    localparam logic [HDR_CNT_W-1:0] HDR_POS_CMD    = HDR_CNT_W'(HDR_BYTES - 1);

    typedef struct packed {
        logic [7:0]       byte_value;
        logic [IDX_W-1:0] byte_index;
        logic             is_crc;
        logic [7:0]       command_code;
        logic [LEN_W-1:0] payload_length;
        logic             frame_done;
        logic [ID_W-1:0]  frame_id;
        logic             completed_slot;
        logic             ack_error;
    } result_t;

endpackage

// ===== sv/stx_ifs.sv =====
// ----------------------------------------------------------------------------
// stx channel interfaces
// Valid/ready channels for received bytes, result items and the mode register.
// ----------------------------------------------------------------------------
interface stx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface stx_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic [16:0] byte_index;
    logic        is_crc;
    logic [7:0]  command_code;
    logic [15:0] payload_length;
    logic        frame_done;
    logic [31:0] frame_id;
    logic        completed_slot;
    logic        ack_error;

    modport source (
        output valid, output byte_value, output byte_index, output is_crc,
        output command_code, output payload_length, output frame_done,
        output frame_id, output completed_slot, output ack_error,
        input ready
    );
    modport sink (
        input valid, input byte_value, input byte_index, input is_crc,
        input command_code, input payload_length, input frame_done,
        input frame_id, input completed_slot, input ack_error,
        output ready
    );
endinterface

interface stx_cfg_if;
    logic valid;
    logic ready;
    logic scan_continuous;

    modport source (output valid, output scan_continuous, input ready);
    modport sink   (input valid, input scan_continuous, output ready);
endinterface

// ===== sv/sensor_telegram_receiver.sv =====
// ----------------------------------------------------------------------------
// sensor_telegram_receiver
// Parses length-prefixed telegrams from a byte stream and emits data items.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one received byte per item. In request mode a telegram opens with
//         the acknowledge byte 0x06; any other byte there yields one error
//         item and the receiver drops every later byte until reset.
//   res : one item per data or CRC byte, with its index, the command and the
//         payload length. The last byte of a telegram carries frame_done,
//         the telegram id and the buffer slot it completes.
//   cfg : mode register, always ready. Write it only while the block is idle;
//         it is sampled when a telegram completes.
// Each item is registered into the result register, or into the skid register
// while res stalls. The block takes one byte per cycle; the only limit is the
// two-entry output buffer (result register plus skid), which lets rx keep
// moving after res stalls until the skid fills and holds rx ready low only
// while both are full. Acknowledge and header bytes make no item and pass
// through at full rate. Reset returns to acknowledge wait, request mode, id 0,
// slot 0, and empties the output buffer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sensor_telegram_receiver (
    input  logic   clk,
    input  logic   rst_n,
    stx_byte_if.sink     rx,
    stx_result_if.source res,
    stx_cfg_if.sink      cfg
);
    import stx_pkg::*;

    typedef enum logic [1:0] {
        PH_ACK,
        PH_HDR,
        PH_DATA,
        PH_HALT
    } phase_t;

    phase_t                 phase_reg,    phase_next;
    logic [HDR_CNT_W-1:0]   hdr_cnt_reg,  hdr_cnt_next;
    logic [7:0]             len_lo_reg,   len_lo_next;
    logic [7:0]             len_hi_reg,   len_hi_next;
    logic [7:0]             cmd_reg,      cmd_next;
    logic [LEN_W-1:0]       plen_reg,     plen_next;
    logic [IDX_W-1:0]       data_cnt_reg, data_cnt_next;
    logic [ID_W-1:0]        id_reg,       id_next;
    logic                   slot_reg,     slot_next;
    logic                   scan_reg;

    result_t out_reg,  out_next;
    logic    out_valid_reg, out_valid_next;
    result_t skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    result_t          new_res;
    logic             new_valid;
    logic             accept;
    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] total;

    assign rx.ready  = !skid_valid_reg;
    assign cfg.ready = 1'b1;
    assign accept    = rx.valid && rx.ready;

    assign idx_inc = data_cnt_reg + IDX_W'(1);
    assign total   = {1'b0, plen_reg} + IDX_W'(CRC_BYTES);

    // Telegram state update and result build for one accepted byte
    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        len_lo_next   = len_lo_reg;
        len_hi_next   = len_hi_reg;
        cmd_next      = cmd_reg;
        plen_next     = plen_reg;
        data_cnt_next = data_cnt_reg;
        id_next       = id_reg;
        slot_next     = slot_reg;
        new_res       = '0;
        new_valid     = 1'b0;

        if (accept)
        begin
            case (phase_reg)
                PH_ACK:
                begin
                    if (rx.rx_byte == ACK_CODE)
                    begin
                        phase_next   = PH_HDR;
                        hdr_cnt_next = '0;
                    end
                    else
                    begin
                        phase_next         = PH_HALT;
                        new_res.byte_value = rx.rx_byte;
                        new_res.ack_error  = 1'b1;
                        new_valid          = 1'b1;
                    end
                end
                PH_HDR:
                begin
                    if (hdr_cnt_reg == HDR_POS_LEN_LO)
                        len_lo_next = rx.rx_byte;
                    if (hdr_cnt_reg == HDR_POS_LEN_HI)
                        len_hi_next = rx.rx_byte;
                    if (hdr_cnt_reg == HDR_POS_CMD)
                    begin
                        cmd_next      = rx.rx_byte;
                        plen_next     = {len_hi_reg, len_lo_reg} - LEN_W'(1);
                        hdr_cnt_next  = '0;
                        data_cnt_next = '0;
                        phase_next    = PH_DATA;
                    end
                    else
                        hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
                end
                PH_DATA:
                begin
                    new_res.byte_value     = rx.rx_byte;
                    new_res.byte_index     = data_cnt_reg;
                    new_res.is_crc         = data_cnt_reg >= {1'b0, plen_reg};
                    new_res.command_code   = cmd_reg;
                    new_res.payload_length = plen_reg;
                    new_valid              = 1'b1;
                    data_cnt_next          = idx_inc;
                    if (idx_inc >= total)
                    begin
                        new_res.frame_done     = 1'b1;
                        new_res.frame_id       = id_reg;
                        new_res.completed_slot = slot_reg;
                        id_next                = id_reg + ID_W'(1);
                        slot_next              = !slot_reg;
                        data_cnt_next          = '0;
                        phase_next             = scan_reg ? PH_HDR : PH_ACK;
                    end
                end
                default:
                begin
                    // halted: drop the byte
                end
            endcase
        end
    end

    // Output register with a skid stage behind it
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (!out_valid_reg || res.ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = new_res;
                out_valid_next = new_valid;
            end
        end
        else if (new_valid)
        begin
            skid_next       = new_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_ACK;
            hdr_cnt_reg    <= '0;
            len_lo_reg     <= '0;
            len_hi_reg     <= '0;
            cmd_reg        <= '0;
            plen_reg       <= '0;
            data_cnt_reg   <= '0;
            id_reg         <= '0;
            slot_reg       <= 1'b0;
            scan_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            len_lo_reg     <= len_lo_next;
            len_hi_reg     <= len_hi_next;
            cmd_reg        <= cmd_next;
            plen_reg       <= plen_next;
            data_cnt_reg   <= data_cnt_next;
            id_reg         <= id_next;
            slot_reg       <= slot_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg.valid && cfg.ready)
                scan_reg <= cfg.scan_continuous;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.byte_value     = out_reg.byte_value;
    assign res.byte_index     = out_reg.byte_index;
    assign res.is_crc         = out_reg.is_crc;
    assign res.command_code   = out_reg.command_code;
    assign res.payload_length = out_reg.payload_length;
    assign res.frame_done     = out_reg.frame_done;
    assign res.frame_id       = out_reg.frame_id;
    assign res.completed_slot = out_reg.completed_slot;
    assign res.ack_error      = out_reg.ack_error;

    `ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `ASSERT_IMP(a_halt_silent, phase_reg == PH_HALT, !new_valid, "item made while halted")
    `ASSERT_IMP(a_done_is_crc, out_valid_reg && out_reg.frame_done, out_reg.is_crc,
        "telegram end not on a CRC byte")
    `ASSERT_NXT(a_error_halts, accept && new_valid && new_res.ack_error,
        phase_reg == PH_HALT, "receiver did not halt after error")

endmodule

// ===== bench/tb_sensor_telegram_receiver.sv =====
// ----------------------------------------------------------------------------
// tb_sensor_telegram_receiver
// Self-checking bench for the telegram receiver. Drives acknowledge, header
// and data bytes in request and continuous mode with random idles on both
// channels, predicts every result item and checks each against the block.
// ----------------------------------------------------------------------------
module tb_sensor_telegram_receiver;
    import stx_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_ITEMS    = 1600;

    typedef enum logic [1:0] {WAIT_ACK, IN_HEADER, IN_DATA, HALTED} rx_phase_t;

    class telegram_scoreboard;
        logic              scan_mode;
        rx_phase_t         phase;
        logic [2:0]        hdr_cnt;
        logic [7:0]        len_lo;
        logic [7:0]        len_hi;
        logic [7:0]        cmd;
        logic [LEN_W-1:0]  pay_len;
        logic [IDX_W-1:0]  data_cnt;
        logic [ID_W-1:0]   next_id;
        logic              slot;
        result_t           expected_q[$];
        int                failures;

        function new();
            scan_mode = 1'b0;
            phase     = WAIT_ACK;
            hdr_cnt   = '0;
            len_lo    = '0;
            len_hi    = '0;
            cmd       = '0;
            pay_len   = '0;
            data_cnt  = '0;
            next_id   = '0;
            slot      = 1'b0;
            failures  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the receiver state by one accepted byte
        function void note_rx_byte(logic [7:0] b);
            result_t r;
            r = '0;
            case (phase)
                WAIT_ACK:
                begin
                    if (b == ACK_CODE)
                    begin
                        phase   = IN_HEADER;
                        hdr_cnt = '0;
                    end
                    else
                    begin
                        phase       = HALTED;
                        r.byte_value = b;
                        r.ack_error  = 1'b1;
                        expected_q.push_back(r);
                    end
                end
                IN_HEADER:
                begin
                    if (hdr_cnt == HDR_POS_LEN_LO)
                        len_lo = b;
                    else if (hdr_cnt == HDR_POS_LEN_HI)
                        len_hi = b;
                    else if (hdr_cnt == HDR_POS_CMD)
                        cmd = b;
                    hdr_cnt = hdr_cnt + 3'd1;
                    if (hdr_cnt == HDR_BYTES)
                    begin
                        pay_len  = {len_hi, len_lo} - 16'd1;
                        hdr_cnt  = '0;
                        data_cnt = '0;
                        phase    = IN_DATA;
                    end
                end
                IN_DATA:
                begin
                    r.byte_value     = b;
                    r.byte_index     = data_cnt;
                    r.is_crc         = (data_cnt >= pay_len);
                    r.command_code   = cmd;
                    r.payload_length = pay_len;
                    if (int'(data_cnt) + 1 == int'(pay_len) + CRC_BYTES)
                    begin
                        r.frame_done     = 1'b1;
                        r.frame_id       = next_id;
                        r.completed_slot = slot;
                        next_id  = next_id + ID_W'(1);
                        slot     = ~slot;
                        data_cnt = '0;
                        phase    = scan_mode ? IN_HEADER : WAIT_ACK;
                    end
                    else
                        data_cnt = data_cnt + IDX_W'(1);
                    expected_q.push_back(r);
                end
                default:
                    ;
            endcase
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (got_v !== exp_v)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
                failures++;
            end
        endfunction

        function void check_item(result_t got);
            result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result item with nothing expected: byte_value 0x%0h", got.byte_value);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            check_field("byte_value", e.byte_value, got.byte_value);
            check_field("byte_index", e.byte_index, got.byte_index);
            check_field("is_crc", e.is_crc, got.is_crc);
            check_field("command_code", e.command_code, got.command_code);
            check_field("payload_length", e.payload_length, got.payload_length);
            check_field("frame_done", e.frame_done, got.frame_done);
            check_field("frame_id", e.frame_id, got.frame_id);
            check_field("completed_slot", e.completed_slot, got.completed_slot);
            check_field("ack_error", e.ack_error, got.ack_error);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    stx_byte_if   rx_if();
    stx_result_if res_if();
    stx_cfg_if    cfg_if();

    telegram_scoreboard sb = new();

    logic idle_on;
    int   rx_count;
    int   res_hold;
    int   quiet_cycles;

    sensor_telegram_receiver i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: hold ready low after each item while res_hold runs down; res_hold is random while idles are on
    initial
    begin
        res_if.ready = 1'b0;
        res_hold     = 0;
        forever
        begin
            @(negedge clk);
            if (res_hold > 0)
            begin
                res_hold--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.byte_value     = res_if.byte_value;
            got.byte_index     = res_if.byte_index;
            got.is_crc         = res_if.is_crc;
            got.command_code   = res_if.command_code;
            got.payload_length = res_if.payload_length;
            got.frame_done     = res_if.frame_done;
            got.frame_id       = res_if.frame_id;
            got.completed_slot = res_if.completed_slot;
            got.ack_error      = res_if.ack_error;
            sb.check_item(got);
            res_hold = idle_on ? $urandom_range(0, 9) : 0;
        end
    end

    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        sb.note_rx_byte(b);
        rx_count++;
    endtask

    // Hold the byte stream until every expected item has arrived
    task automatic drain();
        @(negedge clk);
        rx_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        @(negedge clk);
        cfg_if.valid           <= 1'b1;
        cfg_if.scan_continuous <= mode;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        sb.scan_mode = mode;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_telegram(input logic [15:0] len_field, input logic [7:0] cmd_byte);
        int n;
        if (sb.phase == WAIT_ACK)
            send_byte(ACK_CODE);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        send_byte(len_field[7:0]);
        send_byte(len_field[15:8]);
        send_byte(cmd_byte);
        n = int'(len_field - 16'd1) + CRC_BYTES;
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int          start_count;
        int          tel_num;
        logic [15:0] len_field;
        logic [7:0]  bad_ack;

        rst_n                  = 1'b0;
        idle_on                = 1'b1;
        rx_count               = 0;
        quiet_cycles           = 0;
        rx_if.valid            = 1'b0;
        rx_if.rx_byte          = '0;
        cfg_if.valid           = 1'b0;
        cfg_if.scan_continuous = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Request mode: CRC-only telegram, then a short one with command zero
        write_mode(1'b0);
        send_telegram(16'h0001, 8'hFF);
        send_telegram(16'h0003, 8'h00);

        // Continuous mode takes effect once the next telegram completes
        drain();
        write_mode(1'b1);
        send_telegram(16'h0002, 8'hA5);

        // Length field with a zero low byte; run it back to back
        idle_on = 1'b0;
        send_telegram(16'h0100, 8'h5A);
        idle_on = 1'b1;

        start_count = rx_count;
        tel_num     = 0;
        while (rx_count - start_count < RANDOM_ITEMS)
        begin
            if (tel_num % 8 == 3)
            begin
                drain();
                write_mode(1'($urandom_range(0, 1)));
            end
            idle_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 19) == 0)
                len_field = 16'($urandom_range(250, 520));
            else
                len_field = 16'($urandom_range(1, 30));
            send_telegram(len_field, 8'($urandom_range(0, 255)));
            tel_num++;
        end
        idle_on = 1'b1;

        // Return to request mode, then reject a bad acknowledge and halt
        drain();
        write_mode(1'b0);
        send_telegram(16'h0002, 8'($urandom_range(0, 255)));
        bad_ack = 8'($urandom_range(0, 254));
        if (bad_ack >= ACK_CODE)
            bad_ack = bad_ack + 8'd1;
        send_byte(bad_ack);
        send_byte(ACK_CODE);
        repeat (3) send_byte(8'($urandom_range(0, 255)));

        drain();
        repeat (10) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
